@@ design/vrt_pkg.sv @@
package vrt_pkg;

  // Configuration register width and index width
  localparam int unsigned REG_W      = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  // Pipeline depth of the rotate datapath (last stage is the output register)
  localparam int unsigned NUM_STAGES = 6;

  // Fractional bits of the rotation term: 2 * Q2.30 * Q2.30 scale
  localparam int unsigned TERM_SHIFT = 59;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROT_X   = 3'd0,
    REG_ROT_Y   = 3'd1,
    REG_ROT_Z   = 3'd2,
    REG_ROT_W   = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } cfg_reg_e;

  localparam logic [REG_W-1:0] ROT_W_RESET = 32'h4000_0000;

  typedef struct packed {
    logic signed [REG_W-1:0] x;
    logic signed [REG_W-1:0] y;
    logic signed [REG_W-1:0] z;
    logic signed [REG_W-1:0] w;
  } rot_t;

  // Per-stage load enables, bit s loads stage register s
  typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

@@ design/vrt_rotate.sv @@
module vrt_rotate import vrt_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic                     clk_i,
  input  stage_en_t                adv_i,
  input  rot_t                     rot_i,
  input  logic [2:0][REG_W-1:0]    shift_i,
  input  logic [2:0][W-1:0]        vec_i,
  output logic [2:0][W-1:0]        res_o,
  output logic                     ovf_o
);

  localparam int unsigned P_W  = REG_W + W;          // u * v
  localparam int unsigned C_W  = P_W + 1;            // cross product
  localparam int unsigned CH_W = C_W - 32;           // upper slice of c
  localparam int unsigned HP_W = REG_W + CH_W;       // u * c_hi
  localparam int unsigned LP_W = REG_W + 33;         // u * c_lo
  localparam int unsigned H_W  = HP_W + 2;
  localparam int unsigned L_W  = LP_W + 2;
  localparam int unsigned TR_W = H_W + 32 + 2;       // term + half
  localparam int unsigned R_W  = TR_W - TERM_SHIFT;  // rounded term
  localparam int unsigned S_W  = ((R_W > REG_W + 1) ? R_W : REG_W + 1) + 2;

  localparam logic [TR_W-1:0] HALF = TR_W'(1) << (TERM_SHIFT - 1);

  logic signed [REG_W-1:0] ux, uy, uz, us;
  assign ux = rot_i.x;
  assign uy = rot_i.y;
  assign uz = rot_i.z;
  assign us = rot_i.w;

  // source vector rides along to the final add
  logic [2:0][W-1:0] vpipe_q [NUM_STAGES-1];

  // stage 1: products u * v
  logic signed [P_W-1:0] prod_d [6];
  logic signed [P_W-1:0] prod_q [6];
  // stage 2: cross product c = u x v
  logic signed [C_W-1:0] c_d [3];
  logic signed [C_W-1:0] c_q [3];
  // stage 3: split partial products of s*c and u x c
  logic signed [HP_W-1:0] hh_d [3][3];
  logic signed [HP_W-1:0] hh_q [3][3];
  logic signed [LP_W-1:0] ll_d [3][3];
  logic signed [LP_W-1:0] ll_q [3][3];
  // stage 4: upper and lower partial sums
  logic signed [H_W-1:0] hi_d [3];
  logic signed [H_W-1:0] hi_q [3];
  logic signed [L_W-1:0] lo_d [3];
  logic signed [L_W-1:0] lo_q [3];
  // stage 5: rounded term
  logic [TR_W-1:0]       tr   [3];
  logic signed [R_W-1:0] r_d  [3];
  logic signed [R_W-1:0] r_q  [3];
  // stage 6: add, saturate
  logic signed [S_W-1:0] sum  [3];
  logic [2:0][W-1:0]     res_d;
  logic [2:0][W-1:0]     res_q;
  logic [2:0]            sat_d;
  logic                  ovf_q;

  logic signed [W-1:0] vx, vy, vz;
  assign vx = $signed(vec_i[0]);
  assign vy = $signed(vec_i[1]);
  assign vz = $signed(vec_i[2]);

  always_comb begin
    prod_d[0] = uy * vz;
    prod_d[1] = uz * vy;
    prod_d[2] = uz * vx;
    prod_d[3] = ux * vz;
    prod_d[4] = ux * vy;
    prod_d[5] = uy * vx;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_d[k] = C_W'(prod_q[2*k]) - C_W'(prod_q[2*k+1]);
    end
  end

  // c = c_hi * 2^32 + c_lo keeps every multiply near 32x32
  logic signed [CH_W-1:0] ch [3];
  logic signed [32:0]     cl [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ch[k] = $signed(c_q[k][C_W-1:32]);
      cl[k] = $signed({1'b0, c_q[k][31:0]});
    end
    // d0 = uy*c2 - uz*c1, d1 = uz*c0 - ux*c2, d2 = ux*c1 - uy*c0
    hh_d[0][0] = us * ch[0];  ll_d[0][0] = us * cl[0];
    hh_d[0][1] = uy * ch[2];  ll_d[0][1] = uy * cl[2];
    hh_d[0][2] = uz * ch[1];  ll_d[0][2] = uz * cl[1];
    hh_d[1][0] = us * ch[1];  ll_d[1][0] = us * cl[1];
    hh_d[1][1] = uz * ch[0];  ll_d[1][1] = uz * cl[0];
    hh_d[1][2] = ux * ch[2];  ll_d[1][2] = ux * cl[2];
    hh_d[2][0] = us * ch[2];  ll_d[2][0] = us * cl[2];
    hh_d[2][1] = ux * ch[1];  ll_d[2][1] = ux * cl[1];
    hh_d[2][2] = uy * ch[0];  ll_d[2][2] = uy * cl[0];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hi_d[k] = H_W'(hh_q[k][0]) + H_W'(hh_q[k][1]) - H_W'(hh_q[k][2]);
      lo_d[k] = L_W'(ll_q[k][0]) + L_W'(ll_q[k][1]) - L_W'(ll_q[k][2]);
    end
  end

  // round to nearest, ties up, then drop the term scale
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tr[k]  = (TR_W'(hi_q[k]) << 32) + TR_W'(lo_q[k]) + HALF;
      r_d[k] = $signed(tr[k][TR_W-1:TERM_SHIFT]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = S_W'(r_q[k]) + S_W'($signed(vpipe_q[NUM_STAGES-2][k]))
             + S_W'($signed(shift_i[k]));
      if (sum[k][S_W-1:W-1] == '0 || sum[k][S_W-1:W-1] == '1) begin
        res_d[k] = sum[k][W-1:0];
        sat_d[k] = 1'b0;
      end else begin
        res_d[k] = sum[k][S_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        sat_d[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      prod_q     <= prod_d;
      vpipe_q[0] <= vec_i;
    end
    if (adv_i[1]) begin
      c_q        <= c_d;
      vpipe_q[1] <= vpipe_q[0];
    end
    if (adv_i[2]) begin
      hh_q       <= hh_d;
      ll_q       <= ll_d;
      vpipe_q[2] <= vpipe_q[1];
    end
    if (adv_i[3]) begin
      hi_q       <= hi_d;
      lo_q       <= lo_d;
      vpipe_q[3] <= vpipe_q[2];
    end
    if (adv_i[4]) begin
      r_q        <= r_d;
      vpipe_q[4] <= vpipe_q[3];
    end
    if (adv_i[5]) begin
      res_q <= res_d;
      ovf_q <= |sat_d;
    end
  end

  assign res_o = res_q;
  assign ovf_o = ovf_q;

endmodule

@@ design/vertex_rigid_transform.sv @@
// Channel | Dir | Fields, lowest bit first
// --------+-----+----------------------------------------------------------
// s_axis  | in  | pos_in_x/y/z (COORD_WIDTH each), nrm_in_x/y/z (NORMAL_WIDTH)
// m_axis  | out | pos_out_x/y/z, nrm_out_x/y/z, overflow
// cfg     | in  | write only: cfg_we_i, cfg_addr_i (0..6), cfg_wdata_i
//
// One vertex per clock sustained while m_axis_tready keeps results leaving;
// each vertex passes through the six-stage multiply/add pipeline (u*v, cross
// product, split partial products, partial sums, rounding, final add +
// saturate into the output register).
// Reset clears the stage valid bits and loads the identity pose.
// Each stage holds only while it is full and the one after it is blocked,
// so bubbles close up; input flows while a result waits and a stage is free.
module vertex_rigid_transform import vrt_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = 32,
  parameter int unsigned NORMAL_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [REG_W-1:0]          cfg_wdata_i,
  // vertex in
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // pos_in_x, pos_in_y, pos_in_z, nrm_in_x, nrm_in_y, nrm_in_z, zero pad
  input  logic [((3*COORD_WIDTH + 3*NORMAL_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // vertex out
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // pos_out_x, pos_out_y, pos_out_z, nrm_out_x, nrm_out_y, nrm_out_z,
  // overflow, zero pad
  output logic [((3*COORD_WIDTH + 3*NORMAL_WIDTH + 8) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int unsigned FIELD_BITS = 3 * COORD_WIDTH + 3 * NORMAL_WIDTH;
  localparam int unsigned OUT_W      = ((FIELD_BITS + 1 + 7) / 8) * 8;
  localparam int unsigned NRM_LSB    = 3 * COORD_WIDTH;

  // ---------------------------------------------------------------
  // Pose registers
  // ---------------------------------------------------------------
  rot_t                    rot_q;
  logic signed [REG_W-1:0] shift_x_q, shift_y_q, shift_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q.x   <= '0;
      rot_q.y   <= '0;
      rot_q.z   <= '0;
      rot_q.w   <= ROT_W_RESET;
      shift_x_q <= '0;
      shift_y_q <= '0;
      shift_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_ROT_X:   rot_q.x   <= cfg_wdata_i;
        REG_ROT_Y:   rot_q.y   <= cfg_wdata_i;
        REG_ROT_Z:   rot_q.z   <= cfg_wdata_i;
        REG_ROT_W:   rot_q.w   <= cfg_wdata_i;
        REG_SHIFT_X: shift_x_q <= cfg_wdata_i;
        REG_SHIFT_Y: shift_y_q <= cfg_wdata_i;
        REG_SHIFT_Z: shift_z_q <= cfg_wdata_i;
        default: ;  // index beyond the map: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Stage valid bits and per-stage flow control
  // ---------------------------------------------------------------
  logic [NUM_STAGES-1:0] valid_q;
  stage_en_t             stg_rdy;

  // a stage loads when empty or when its content moves on
  always_comb begin
    stg_rdy[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_axis_tready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      stg_rdy[s] = !valid_q[s] || stg_rdy[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stg_rdy[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (stg_rdy[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  assign s_axis_tready = stg_rdy[0];
  assign m_axis_tvalid = valid_q[NUM_STAGES-1];

  // ---------------------------------------------------------------
  // Datapaths: position (with translation) and normal (rotation only)
  // ---------------------------------------------------------------
  logic [2:0][COORD_WIDTH-1:0]  pos_in, pos_out;
  logic [2:0][NORMAL_WIDTH-1:0] nrm_in, nrm_out;
  logic                         pos_ovf, nrm_ovf;
  logic [2:0][REG_W-1:0]        pos_shift;

  // translation differs per axis, one shift per position component
  assign pos_shift[0] = shift_x_q;
  assign pos_shift[1] = shift_y_q;
  assign pos_shift[2] = shift_z_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos_in[k] = s_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH];
      nrm_in[k] = s_axis_tdata[NRM_LSB + k*NORMAL_WIDTH +: NORMAL_WIDTH];
    end
  end

  vrt_rotate #(
    .W (COORD_WIDTH)
  ) u_pos (
    .clk_i   (clk_i),
    .adv_i   (stg_rdy),
    .rot_i   (rot_q),
    .shift_i (pos_shift),
    .vec_i   (pos_in),
    .res_o   (pos_out),
    .ovf_o   (pos_ovf)
  );

  vrt_rotate #(
    .W (NORMAL_WIDTH)
  ) u_nrm (
    .clk_i   (clk_i),
    .adv_i   (stg_rdy),
    .rot_i   (rot_q),
    .shift_i ('0),
    .vec_i   (nrm_in),
    .res_o   (nrm_out),
    .ovf_o   (nrm_ovf)
  );

  assign m_axis_tdata = OUT_W'({pos_ovf || nrm_ovf, nrm_out, pos_out});

endmodule

@@ dv/vertex_rigid_transform_test.sv @@
module vertex_rigid_transform_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vrt_pkg::*;

  // Block runs at its default widths: Q16.16 positions, Q2.14 normals
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned NORMAL_W  = 16;
  localparam int unsigned VTX_IN_W  = 3 * COORD_W + 3 * NORMAL_W;                 // 144, byte aligned
  localparam int unsigned VTX_OUT_W = ((3 * COORD_W + 3 * NORMAL_W + 1 + 7) / 8) * 8; // 152

  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 65;

  // Address 7 decodes to no register; writes to it must be dropped
  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

  localparam logic [31:0] CMAX = 32'h7fff_ffff;
  localparam logic [31:0] CMIN = 32'h8000_0000;
  localparam logic [15:0] NMAX = 16'h7fff;
  localparam logic [15:0] NMIN = 16'h8000;

  // Q2.30 values used by the directed pose settings
  localparam logic [31:0] Q_HALF    = 32'h2000_0000;  // 0.5, gives exact rounding ties
  localparam logic [31:0] Q_COS45   = 32'h2d41_3ccd;  // cos(45 deg)

  typedef logic signed [127:0] acc_t;

  localparam acc_t ROUND_HALF = acc_t'(1) <<< (TERM_SHIFT - 1);

  typedef struct packed {
    logic [31:0] px, py, pz;
    logic [15:0] nx, ny, nz;
  } vertex_t;

  typedef struct packed {
    logic [31:0] px, py, pz;
    logic [15:0] nx, ny, nz;
    logic        ovf;
  } xformed_t;

  // One row of the directed table: either a register write or a vertex,
  // the latter optionally with a hand-written expected result
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_ADDR_W-1:0] addr;
    logic [REG_W-1:0]      wdata;
    vertex_t               vtx;
    logic                  has_exp;
    xformed_t              exp_xf;
  } stim_row_t;

  typedef enum logic [1:0] {
    RX_STREAM,    // always ready
    RX_RANDOM,    // ready at random, with probability three in four
    RX_PERIODIC,  // fixed pattern, ready while the 3-bit tick is below 5
    RX_STARVED    // mostly stalled, long back-pressure
  } rx_mode_e;

  // ---------------------------------------------------------------------------
  // DUT interface
  // ---------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [REG_W-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // pos_in_x, pos_in_y, pos_in_z, nrm_in_x, nrm_in_y, nrm_in_z (lowest bit first)
  logic [VTX_IN_W-1:0]   s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // pos_out_x, pos_out_y, pos_out_z, nrm_out_x, nrm_out_y, nrm_out_z, overflow, zero pad
  logic [VTX_OUT_W-1:0]  m_axis_tdata;

  vertex_rigid_transform #(
    .COORD_WIDTH  (COORD_W),
    .NORMAL_WIDTH (NORMAL_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Pose shadow: what the block should hold after the writes issued so far.
  // Only ever changed while nothing is in flight.
  // ---------------------------------------------------------------------------
  logic signed [31:0] q_x  = '0;
  logic signed [31:0] q_y  = '0;
  logic signed [31:0] q_z  = '0;
  logic signed [31:0] q_w  = ROT_W_RESET;
  logic signed [31:0] sh_x = '0;
  logic signed [31:0] sh_y = '0;
  logic signed [31:0] sh_z = '0;

  xformed_t expected_xforms[$];
  int       mismatch_count = 0;
  int       result_count   = 0;
  int       cycle_count    = 0;

  // Vertex on the input bus, plus the hand-written result when a table row has one
  vertex_t  tx_vertex   = '0;
  logic     tx_exp_on   = 1'b0;
  xformed_t tx_exp      = '0;

  // Sender pacing
  int burst_left = 0;
  int gap_max    = 3;
  int burst_max  = 4;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Rounded rotation term for component k of v:
  //   2*(s*(u x v) + u x (u x v)), carried at 2^60 scale, rounded to v's LSB
  //   (add half, arithmetic shift; ties go toward +inf)
  function automatic acc_t rot_delta(int k, acc_t vx, acc_t vy, acc_t vz);
    acc_t ux, uy, uz, s, cx, cy, cz, c, d;
    ux = q_x;
    uy = q_y;
    uz = q_z;
    s  = q_w;
    cx = uy * vz - uz * vy;
    cy = uz * vx - ux * vz;
    cz = ux * vy - uy * vx;
    case (k)
      0: begin
        c = cx;
        d = uy * cz - uz * cy;
      end
      1: begin
        c = cy;
        d = uz * cx - ux * cz;
      end
      default: begin
        c = cz;
        d = ux * cy - uy * cx;
      end
    endcase
    return (s * c + d + ROUND_HALF) >>> TERM_SHIFT;
  endfunction

  function automatic acc_t saturate_to(acc_t x, int unsigned w);
    acc_t hi, lo;
    hi = (acc_t'(1) <<< (w - 1)) - 1;
    lo = -(acc_t'(1) <<< (w - 1));
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic xformed_t transform_vertex(vertex_t v);
    acc_t     pv[3], nv[3], sft[3], psat[3], nsat[3];
    acc_t     psum, nsum;
    logic     ovf;
    xformed_t r;
    pv[0]  = $signed(v.px);
    pv[1]  = $signed(v.py);
    pv[2]  = $signed(v.pz);
    nv[0]  = $signed(v.nx);
    nv[1]  = $signed(v.ny);
    nv[2]  = $signed(v.nz);
    sft[0] = sh_x;
    sft[1] = sh_y;
    sft[2] = sh_z;
    ovf    = 1'b0;
    for (int k = 0; k < 3; k++) begin
      // translation applies to the position only; each sum saturates once
      psum    = pv[k] + rot_delta(k, pv[0], pv[1], pv[2]) + sft[k];
      nsum    = nv[k] + rot_delta(k, nv[0], nv[1], nv[2]);
      psat[k] = saturate_to(psum, COORD_W);
      nsat[k] = saturate_to(nsum, NORMAL_W);
      if (psat[k] != psum || nsat[k] != nsum) ovf = 1'b1;
    end
    r.px  = psat[0][31:0];
    r.py  = psat[1][31:0];
    r.pz  = psat[2][31:0];
    r.nx  = nsat[0][15:0];
    r.ny  = nsat[1][15:0];
    r.nz  = nsat[2][15:0];
    r.ovf = ovf;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Table and stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic vertex_t mk_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                        logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
    vertex_t v;
    v.px = px;
    v.py = py;
    v.pz = pz;
    v.nx = nx;
    v.ny = ny;
    v.nz = nz;
    return v;
  endfunction

  function automatic xformed_t mk_xform(vertex_t v, logic ovf);
    xformed_t r;
    r.px  = v.px;
    r.py  = v.py;
    r.pz  = v.pz;
    r.nx  = v.nx;
    r.ny  = v.ny;
    r.nz  = v.nz;
    r.ovf = ovf;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_ADDR_W-1:0] addr, logic [REG_W-1:0] data);
    stim_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.addr   = addr;
    r.wdata  = data;
    return r;
  endfunction

  // Vertex row checked against the predictor
  function automatic stim_row_t vtx_row(vertex_t v);
    stim_row_t r;
    r     = '0;
    r.vtx = v;
    return r;
  endfunction

  // Vertex row with its result written out by hand
  function automatic stim_row_t chk_row(vertex_t v, xformed_t e);
    stim_row_t r;
    r         = '0;
    r.vtx     = v;
    r.has_exp = 1'b1;
    r.exp_xf  = e;
    return r;
  endfunction

  // Random field value of width w in the low bits: extremes, zero, small, anything
  function automatic logic [31:0] rand_field(int unsigned w);
    logic [31:0] top, s;
    top = (32'h1 << (w - 1)) - 1;
    case ($urandom_range(0, 9))
      0: return top;
      1: return ~top;
      2: return '0;
      3, 4, 5: begin
        s = $urandom_range(0, 32'h1 << (w - 3));
        if ($urandom_range(0, 1) == 1) s = -s;
        return s;
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR result %0d: %s", $realtime, result_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Register write; the shadow follows so later predictions see the new pose
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [REG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = addr;
    cfg_wdata_i = data;
    case (addr)
      REG_ROT_X:   q_x  = data;
      REG_ROT_Y:   q_y  = data;
      REG_ROT_Z:   q_z  = data;
      REG_ROT_W:   q_w  = data;
      REG_SHIFT_X: sh_x = data;
      REG_SHIFT_Y: sh_y = data;
      REG_SHIFT_Z: sh_z = data;
      default: ;  // unmapped index, write is dropped
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Drop valid and let every outstanding result come back. One result per
  // vertex, so an empty queue means the pipeline is empty.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    tx_exp_on     = 1'b0;
    burst_left    = 0;
    while (expected_xforms.size() != 0) @(posedge clk_i);
  endtask

  // One input transaction. Valid stays high across a burst; a random gap
  // opens only when a new burst starts.
  task automatic send_vertex(vertex_t v, logic has_exp, xformed_t e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap        = $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    tx_vertex     = v;
    tx_exp_on     = has_exp;
    tx_exp        = e;
    s_axis_tdata  = {v.nz, v.ny, v.nx, v.pz, v.py, v.px};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: a mode held for a random stretch, then another
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode      = RX_STREAM;
  int          rx_mode_left = 0;
  logic [2:0]  rx_tick      = '0;

  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_e'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(32, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    rx_tick <= rx_tick + 3'd1;
    case (rx_mode)
      RX_STREAM:   m_axis_tready <= 1'b1;
      RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: m_axis_tready <= (rx_tick < 3'd5);
      default:     m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transaction, check each output transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    xformed_t got, want;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_xforms = {expected_xforms,
                         (tx_exp_on ? tx_exp : transform_vertex(tx_vertex))};
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.px  = m_axis_tdata[31:0];
      got.py  = m_axis_tdata[63:32];
      got.pz  = m_axis_tdata[95:64];
      got.nx  = m_axis_tdata[111:96];
      got.ny  = m_axis_tdata[127:112];
      got.nz  = m_axis_tdata[143:128];
      got.ovf = m_axis_tdata[144];
      if (expected_xforms.size() == 0) begin
        report_mismatch("output transaction with no vertex outstanding");
      end else begin
        want = expected_xforms.pop_front();
        check_field("pos_x", got.px, want.px);
        check_field("pos_y", got.py, want.py);
        check_field("pos_z", got.pz, want.pz);
        check_field("nrm_x", {16'h0, got.nx}, {16'h0, want.nx});
        check_field("nrm_y", {16'h0, got.ny}, {16'h0, want.ny});
        check_field("nrm_z", {16'h0, got.nz}, {16'h0, want.nz});
        check_field("overflow", {31'h0, got.ovf}, {31'h0, want.ovf});
      end
      result_count++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** vertex_rigid_transform: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t directed[$];
    vertex_t   v;
    rot_t      q;
    real       ra, rb, rc, rd, rn;

    // Identity pose out of reset: every vertex comes back unchanged
    directed = {directed, chk_row(mk_vertex(0, 0, 0, 0, 0, 0),
                                  mk_xform(mk_vertex(0, 0, 0, 0, 0, 0), 1'b0))};
    v = mk_vertex(CMAX, CMAX, CMAX, NMAX, NMAX, NMAX);
    directed = {directed, chk_row(v, mk_xform(v, 1'b0))};
    v = mk_vertex(CMIN, CMIN, CMIN, NMIN, NMIN, NMIN);
    directed = {directed, chk_row(v, mk_xform(v, 1'b0))};
    v = mk_vertex(32'h1234_5678, 32'hffff_ffff, 32'h8000_0001, 16'h0001, 16'hffff, 16'h4000);
    directed = {directed, chk_row(v, mk_xform(v, 1'b0))};

    // Translation only: position saturates both ways, normal untouched
    directed = {directed, cfg_row(REG_SHIFT_X, 32'h0000_0001)};
    directed = {directed, cfg_row(REG_SHIFT_Y, 32'hffff_ffff)};
    directed = {directed, cfg_row(REG_SHIFT_Z, CMAX)};
    directed = {directed, chk_row(mk_vertex(CMAX, CMAX, CMAX, NMAX, NMIN, 0),
                                  mk_xform(mk_vertex(CMAX, 32'h7fff_fffe, CMAX,
                                                     NMAX, NMIN, 0), 1'b1))};
    directed = {directed, chk_row(mk_vertex(CMIN, CMIN, CMIN, 0, 0, 0),
                                  mk_xform(mk_vertex(32'h8000_0001, CMIN, 32'hffff_ffff,
                                                     0, 0, 0), 1'b1))};
    directed = {directed, chk_row(mk_vertex(0, 0, 0, 0, 0, 0),
                                  mk_xform(mk_vertex(1, 32'hffff_ffff, CMAX, 0, 0, 0),
                                           1'b0))};
    // write to the unmapped index must leave the pose alone
    directed = {directed, cfg_row(REG_NONE, 32'hdead_beef)};
    directed = {directed, chk_row(mk_vertex(0, 0, 0, 0, 0, 0),
                                  mk_xform(mk_vertex(1, 32'hffff_ffff, CMAX, 0, 0, 0),
                                           1'b0))};

    // s = uz = 0.5: a unit step along x or y lands exactly on a rounding tie,
    // which must go toward +inf
    directed = {directed, cfg_row(REG_SHIFT_X, 0)};
    directed = {directed, cfg_row(REG_SHIFT_Y, 0)};
    directed = {directed, cfg_row(REG_SHIFT_Z, 0)};
    directed = {directed, cfg_row(REG_ROT_Z, Q_HALF)};
    directed = {directed, cfg_row(REG_ROT_W, Q_HALF)};
    directed = {directed, chk_row(mk_vertex(1, 0, 0, 16'hffff, 0, 0),
                                  mk_xform(mk_vertex(1, 1, 0, 0, 0, 0), 1'b0))};
    directed = {directed, chk_row(mk_vertex(32'hffff_ffff, 0, 0, 16'h0001, 0, 0),
                                  mk_xform(mk_vertex(0, 0, 0, 16'h0001, 16'h0001, 0),
                                           1'b0))};

    // Quarter turn about z
    directed = {directed, cfg_row(REG_ROT_Z, Q_COS45)};
    directed = {directed, cfg_row(REG_ROT_W, Q_COS45)};
    directed = {directed, vtx_row(mk_vertex(32'h0001_0000, 0, 0, 16'h4000, 0, 0))};
    directed = {directed, vtx_row(mk_vertex(32'h0123_4567, 32'hfedc_ba98, 32'h0000_8000,
                                            16'h2000, 16'he000, 16'h2d41))};

    // Far from unit, every register but SHIFT_Z at an extreme: heavy saturation
    directed = {directed, cfg_row(REG_ROT_X, CMAX)};
    directed = {directed, cfg_row(REG_ROT_Y, CMIN)};
    directed = {directed, cfg_row(REG_ROT_Z, CMAX)};
    directed = {directed, cfg_row(REG_ROT_W, CMIN)};
    directed = {directed, cfg_row(REG_SHIFT_X, CMIN)};
    directed = {directed, cfg_row(REG_SHIFT_Y, CMAX)};
    directed = {directed, chk_row(mk_vertex(0, 0, 0, 0, 0, 0),
                                  mk_xform(mk_vertex(CMIN, CMAX, 0, 0, 0, 0), 1'b0))};
    directed = {directed, vtx_row(mk_vertex(CMAX, CMAX, CMAX, NMAX, NMAX, NMAX))};
    directed = {directed, vtx_row(mk_vertex(CMIN, CMIN, CMIN, NMIN, NMIN, NMIN))};
    directed = {directed, vtx_row(mk_vertex(32'h0000_0010, 0, 32'hffff_fff0,
                                            16'h0001, 0, 0))};

    // Reset held, then released away from the active edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_idle();
        write_reg(directed[i].addr, directed[i].wdata);
      end else begin
        send_vertex(directed[i].vtx, directed[i].has_exp, directed[i].exp_xf);
      end
    end

    // Random phases: new pose and pacing, then a run of random vertices
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      case ($urandom_range(0, 5))
        4: begin
          // raw register values, extremes included
          q.x = rand_field(32);
          q.y = rand_field(32);
          q.z = rand_field(32);
          q.w = rand_field(32);
        end
        5: begin
          q   = '0;
          q.w = ($urandom_range(0, 1) == 1) ? ROT_W_RESET : -ROT_W_RESET;
        end
        default: begin
          // random unit quaternion, scaled just inside 1.0
          ra = $itor($signed($urandom()));
          rb = $itor($signed($urandom()));
          rc = $itor($signed($urandom()));
          rd = $itor($signed($urandom()));
          rn = $sqrt(ra * ra + rb * rb + rc * rc + rd * rd);
          if (rn < 1.0) rn = 1.0;
          q.x = $rtoi(ra / rn * 1073741823.0);
          q.y = $rtoi(rb / rn * 1073741823.0);
          q.z = $rtoi(rc / rn * 1073741823.0);
          q.w = $rtoi(rd / rn * 1073741823.0);
        end
      endcase
      write_reg(REG_ROT_X, q.x);
      write_reg(REG_ROT_Y, q.y);
      write_reg(REG_ROT_Z, q.z);
      write_reg(REG_ROT_W, q.w);
      write_reg(REG_SHIFT_X, rand_field(32));
      write_reg(REG_SHIFT_Y, rand_field(32));
      write_reg(REG_SHIFT_Z, rand_field(32));

      case ($urandom_range(0, 2))
        0: begin
          gap_max   = 0;   // back-to-back, no idling
          burst_max = 64;
        end
        1: begin
          gap_max   = 2;
          burst_max = 16;
        end
        default: begin
          gap_max   = 8;
          burst_max = 4;
        end
      endcase

      repeat (PHASE_ITEMS) begin
        v.px = rand_field(COORD_W);
        v.py = rand_field(COORD_W);
        v.pz = rand_field(COORD_W);
        v.nx = rand_field(NORMAL_W);
        v.ny = rand_field(NORMAL_W);
        v.nz = rand_field(NORMAL_W);
        send_vertex(v, 1'b0, '0);
      end
    end

    // Drain, then give stray output transactions a chance to show up
    wait_idle();
    repeat (NUM_STAGES * 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** vertex_rigid_transform: PASSED **");
    end else begin
      $display("** vertex_rigid_transform: FAILED **");
    end
    $finish;
  end

endmodule
